// ===== src/pxt_pkg.sv =====
// ============================================================================
// pxt_pkg
// Shared types and constants for the pixel tint and pack pipeline.
// ============================================================================
package pxt_pkg;

  // Register index of the output format select.
  localparam logic REG_HALF_OUTPUT = 1'b0;

  // Format codes.
  localparam logic FMT_BYTE = 1'b0;
  localparam logic FMT_HALF = 1'b1;

  // Alpha lane values for each format.
  localparam logic [15:0] ALPHA_BYTE = 16'h00FF;
  localparam logic [15:0] ALPHA_HALF = 16'h3C00;

  // Shaded value as X/3060: highlighted X = 8c+1020, dimmed X = 9c.
  localparam logic [11:0] HI_OFFSET = 12'd1020;
  localparam logic [21:0] NORM_MIN  = 22'd3060;
  localparam int unsigned NORM_SHIFT_MAX = 9;

  // Significand = floor((256*Y + 382) / 765), where Y = X << p.
  localparam logic [20:0] RND_BIAS  = 21'd382;
  localparam logic [20:0] RECIP_765 = 21'd1403585;  // ceil(2^30 / 765)
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [9:0]  DIV_765   = 10'd765;

  // Byte path: floor(n / 3) for n <= 765.
  localparam logic [9:0] RECIP_3 = 10'd683;         // 2^11 / 3, rounded up

  localparam logic [4:0] EXP_BIAS = 5'd15;

  // Load enables of the four pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pxt_adv_t;

endpackage

// ===== src/pxt_ctrl.sv =====
// ============================================================================
// pxt_ctrl
// Valid bits and per-stage load enables of the four-stage pipeline.
// ============================================================================
module pxt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output pxt_pkg::pxt_adv_t adv
);

  logic [4:1] vld_r;
  logic [4:1] vld_nxt;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    adv.s4 = !vld_r[4] || out_ready;
    adv.s3 = !vld_r[3] || adv.s4;
    adv.s2 = !vld_r[2] || adv.s3;
    adv.s1 = !vld_r[1] || adv.s2;
  end

  always_comb begin
    vld_nxt[1] = adv.s1 ? in_valid  : vld_r[1];
    vld_nxt[2] = adv.s2 ? vld_r[1] : vld_r[2];
    vld_nxt[3] = adv.s3 ? vld_r[2] : vld_r[3];
    vld_nxt[4] = adv.s4 ? vld_r[3] : vld_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = adv.s1;
  assign out_valid = vld_r[4];

endmodule

// ===== src/pxt_front.sv =====
// ============================================================================
// pxt_front
// Shading and normalisation of one channel (pipeline stages one and two).
// ============================================================================
module pxt_front (
  input  logic              clk,
  input  pxt_pkg::pxt_adv_t adv,
  input  logic [7:0]        chan,
  input  logic              highlight,
  output logic [12:0]       norm_r,
  output logic [3:0]        shift_r,
  output logic              nz_r,
  output logic [7:0]        byte_r
);

  logic [11:0] x_nxt;
  logic [7:0]  byte_nxt;
  logic [19:0] third_prod;
  logic [9:0]  shade_n;
  logic [11:0] x_r;
  logic [7:0]  byte_s1_r;
  logic [12:0] norm_nxt;
  logic [3:0]  shift_nxt;
  logic [21:0] x_wide;

  // Stage one: scaled numerator and the 8-bit quotient.
  always_comb begin
    if (highlight) begin
      shade_n  = {1'b0, chan, 1'b0} + 10'd255;
      x_nxt    = {1'b0, chan, 3'b000} + pxt_pkg::HI_OFFSET;
    end else begin
      shade_n  = {2'b00, chan} + {1'b0, chan, 1'b0};
      x_nxt    = {4'h0, chan} + {1'b0, chan, 3'b000};
    end
    third_prod = shade_n * pxt_pkg::RECIP_3;
    byte_nxt   = highlight ? third_prod[18:11] : shade_n[9:2];
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      x_r       <= x_nxt;
      byte_s1_r <= byte_nxt;
    end
  end

  // Stage two: smallest left shift that brings X up to the divisor.
  always_comb begin
    x_wide    = {10'h000, x_r};
    norm_nxt  = '0;
    shift_nxt = '0;
    for (int i = pxt_pkg::NORM_SHIFT_MAX; i >= 0; i--) begin
      if ((x_wide << i) >= pxt_pkg::NORM_MIN) begin
        norm_nxt  = 13'((x_wide << i));
        shift_nxt = 4'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      norm_r  <= norm_nxt;
      shift_r <= shift_nxt;
      nz_r    <= (x_r != 12'h000);
      byte_r  <= byte_s1_r;
    end
  end

endmodule

// ===== src/pxt_back.sv =====
// ============================================================================
// pxt_back
// Rounded significand and binary16 packing of one channel (stages three, four).
// ============================================================================
module pxt_back (
  input  logic              clk,
  input  pxt_pkg::pxt_adv_t adv,
  input  logic [12:0]       norm,
  input  logic [3:0]        shift,
  input  logic              nz,
  input  logic [7:0]        byte_in,
  output logic [15:0]       half_r,
  output logic [7:0]        byte_r
);

  logic [20:0] dvd;
  logic [41:0] prod;
  logic [11:0] quo_r;
  logic [20:0] dvd_r;
  logic [3:0]  shift_s3_r;
  logic        nz_s3_r;
  logic [7:0]  byte_s3_r;
  logic [21:0] back_prod;
  logic [11:0] sig;
  logic [4:0]  bexp;
  logic [15:0] half_nxt;

  // Stage three: quotient estimate by reciprocal multiplication.
  always_comb begin
    dvd  = {norm, 8'h00} + pxt_pkg::RND_BIAS;
    prod = dvd * pxt_pkg::RECIP_765;
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      quo_r      <= prod[pxt_pkg::RECIP_SHIFT +: 12];
      dvd_r      <= dvd;
      shift_s3_r <= shift;
      nz_s3_r    <= nz;
      byte_s3_r  <= byte_in;
    end
  end

  // Stage four: the estimate is exact or one too high; then pack.
  always_comb begin
    back_prod = quo_r * pxt_pkg::DIV_765;
    sig       = (back_prod > {1'b0, dvd_r}) ? quo_r - 12'd1 : quo_r;
    // A carry into bit 11 halves the significand to zero fraction.
    bexp      = pxt_pkg::EXP_BIAS - {1'b0, shift_s3_r} + {4'h0, sig[11]};
    half_nxt  = nz_s3_r ? {1'b0, bexp, sig[9:0]} : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      half_r <= half_nxt;
      byte_r <= byte_s3_r;
    end
  end

endmodule

// ===== src/pixel_tint_pack_fp16.sv =====
// ============================================================================
// pixel_tint_pack_fp16
// Shades a BGR pixel (brighten or dim) and packs it as BGRA bytes or as
// RGBA binary16 values.
// ============================================================================
//
//  Channel  Ports       Payload
//  -------  ----------  ---------------------------------------------------
//  input    in_t*       tdata: blue, green, red; tuser: highlight
//  output   out_t*      tdata: lane0, lane1, lane2, lane3 (16 bits each)
//  config   cfg_p*      register 0 at address 0: half_output
//
//  One pixel is accepted per clock while in_tready is high; each result
//  is registered through the four-stage datapath (shade, normalise,
//  reciprocal multiply, correct and pack).
//  Reset is synchronous and clears the valid bits and the format register.
//  A stall on the output holds each stage; a stage with no valid item still
//  takes new data, so bubbles are squeezed out while the output waits.
//
module pixel_tint_pack_fp16 (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // blue[7:0], green[15:8], red[23:16]
  input  logic        in_tuser,    // highlight
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // lane0, lane1, lane2, lane3 (16 bits each)
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  pxt_pkg::pxt_adv_t adv;
  logic              half_output_r;
  logic              half_output_nxt;
  logic              cfg_wr;
  logic [12:0]       norm [3];
  logic [3:0]        shift [3];
  logic              nz [3];
  logic [7:0]        byte_mid [3];
  logic [15:0]       half_val [3];
  logic [7:0]        byte_val [3];
  logic [7:0]        chan [3];

  // Configuration register write and read.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    half_output_nxt = half_output_r;
    if (cfg_wr && (cfg_paddr[2] == pxt_pkg::REG_HALF_OUTPUT)) begin
      half_output_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_output_r <= pxt_pkg::FMT_BYTE;
    end else begin
      half_output_r <= half_output_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == pxt_pkg::REG_HALF_OUTPUT) ?
                      {31'h0, half_output_r} : 32'h0;

  // Pipeline control.
  pxt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .adv       (adv)
  );

  // One datapath per colour channel: blue, green, red.
  assign chan[0] = in_tdata[7:0];
  assign chan[1] = in_tdata[15:8];
  assign chan[2] = in_tdata[23:16];

  for (genvar i = 0; i < 3; i++) begin : g_chan
    pxt_front u_front (
      .clk       (clk),
      .adv       (adv),
      .chan      (chan[i]),
      .highlight (in_tuser),
      .norm_r    (norm[i]),
      .shift_r   (shift[i]),
      .nz_r      (nz[i]),
      .byte_r    (byte_mid[i])
    );

    pxt_back u_back (
      .clk     (clk),
      .adv     (adv),
      .norm    (norm[i]),
      .shift   (shift[i]),
      .nz      (nz[i]),
      .byte_in (byte_mid[i]),
      .half_r  (half_val[i]),
      .byte_r  (byte_val[i])
    );
  end

  // Lane order: B,G,R,A in byte mode and R,G,B,A in half mode.
  always_comb begin
    if (half_output_r == pxt_pkg::FMT_HALF) begin
      out_tdata = {pxt_pkg::ALPHA_HALF, half_val[0], half_val[1], half_val[2]};
    end else begin
      out_tdata = {pxt_pkg::ALPHA_BYTE, 8'h00, byte_val[2], 8'h00, byte_val[1],
                   8'h00, byte_val[0]};
    end
  end

endmodule
